// File: rtl/core/assert_macros.svh
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked check, ignored while reset is asserted.
`define TTUP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define TTUP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TTUP_ASSERT(lbl, prop, msg)
`define TTUP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/core/ttup_pkg.sv
// Types, character codes and helper functions for the text to unsigned parser.
package ttup_pkg;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LEAD   = 3'd1,
    PH_SIGNED = 3'd2,
    PH_ZERO   = 3'd3,
    PH_DIGITS = 3'd4,
    PH_DONE   = 3'd5
  } ttup_phase_t;

  localparam int unsigned BASE_BITS  = 6;
  localparam int unsigned DIGIT_BITS = 7;

  localparam logic [BASE_BITS-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_BITS-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_BITS-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_HEX   = 6'd16;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [DIGIT_BITS-1:0] NOT_DIGIT = 7'd64;

  typedef struct packed {
    ttup_phase_t            phase;
    logic                   negative;
    logic [BASE_BITS-1:0]   base;
  } ttup_ctrl_t;

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {CH_SPACE, CH_HT, CH_LF, CH_VT, CH_FF, CH_CR};
  endfunction

  // 0..35 for digits and letters, NOT_DIGIT otherwise
  function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'(NOT_DIGIT);
    if (c inside {[CH_0:CH_9]}) begin
      d = c - CH_0;
    end else if (c inside {[CH_UA:CH_UZ]}) begin
      d = c - CH_UA + 8'd10;
    end else if (c inside {[CH_LA:CH_LZ]}) begin
      d = c - CH_LA + 8'd10;
    end
    return d[DIGIT_BITS-1:0];
  endfunction

endpackage

// File: rtl/core/ttup_step.sv
// Next-state logic of the parser for one character: prefix, sign and digit handling.
module ttup_step #(
  parameter int unsigned VALUE_BITS  = 32,
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic [7:0]                      ch_i,
  input  logic                            first_i,
  input  logic [ttup_pkg::BASE_BITS-1:0]  number_base_i,
  input  ttup_pkg::ttup_ctrl_t            ctrl_i,
  input  logic [VALUE_BITS-1:0]           acc_i,
  input  logic [OFFSET_BITS-1:0]          cnt_i,
  output ttup_pkg::ttup_ctrl_t            ctrl_o,
  output logic [VALUE_BITS-1:0]           acc_o,
  output logic [OFFSET_BITS-1:0]          cnt_o,
  output logic                            emit_o,
  output logic [VALUE_BITS-1:0]           value_o,
  output logic [OFFSET_BITS-1:0]          offset_o
);

  ttup_pkg::ttup_ctrl_t                cur;
  logic [VALUE_BITS-1:0]               acc_cur;
  logic [OFFSET_BITS-1:0]              cnt_cur;
  logic [OFFSET_BITS-1:0]              cnt_inc;
  logic [ttup_pkg::DIGIT_BITS-1:0]     dval;
  logic [ttup_pkg::BASE_BITS-1:0]      dbase;
  logic                                start;
  logic                                dig_en;
  logic [VALUE_BITS-1:0]               acc_mac;

  assign dval = ttup_pkg::digit_of(ch_i);

  always_comb begin
    cur     = ctrl_i;
    acc_cur = acc_i;
    cnt_cur = cnt_i;
    if (first_i) begin
      cur.phase    = ttup_pkg::PH_LEAD;
      cur.negative = 1'b0;
      cur.base     = number_base_i;
      acc_cur      = '0;
      cnt_cur      = '0;
    end
    cnt_inc = (cnt_cur == {OFFSET_BITS{1'b1}}) ? cnt_cur : cnt_cur + OFFSET_BITS'(1);

    ctrl_o = cur;
    acc_o  = acc_cur;
    cnt_o  = cnt_cur;
    emit_o = 1'b0;
    start  = 1'b0;
    dig_en = 1'b0;
    dbase  = cur.base;

    case (cur.phase)
      ttup_pkg::PH_LEAD: begin
        if (ttup_pkg::is_blank(ch_i)) begin
          cnt_o = cnt_inc;
        end else if (ch_i == ttup_pkg::CH_PLUS || ch_i == ttup_pkg::CH_MINUS) begin
          ctrl_o.negative = (ch_i == ttup_pkg::CH_MINUS);
          ctrl_o.phase    = ttup_pkg::PH_SIGNED;
          cnt_o           = cnt_inc;
        end else begin
          start = 1'b1;
        end
      end
      ttup_pkg::PH_SIGNED: begin
        start = 1'b1;
      end
      ttup_pkg::PH_ZERO: begin
        if (ch_i == ttup_pkg::CH_LX || ch_i == ttup_pkg::CH_UX) begin
          ctrl_o.base  = ttup_pkg::BASE_HEX;
          ctrl_o.phase = ttup_pkg::PH_DIGITS;
          cnt_o        = cnt_inc;
        end else begin
          dig_en = 1'b1;
          dbase  = (cur.base == ttup_pkg::BASE_AUTO) ? ttup_pkg::BASE_OCT : cur.base;
        end
      end
      ttup_pkg::PH_DIGITS: begin
        dig_en = 1'b1;
      end
      default: begin
      end
    endcase

    // position where a 0x prefix may begin
    if (start) begin
      if ((cur.base == ttup_pkg::BASE_AUTO || cur.base == ttup_pkg::BASE_HEX) &&
          ch_i == ttup_pkg::CH_0) begin
        ctrl_o.phase = ttup_pkg::PH_ZERO;
        cnt_o        = cnt_inc;
      end else begin
        dig_en = 1'b1;
        dbase  = (cur.base == ttup_pkg::BASE_AUTO) ? ttup_pkg::BASE_DEC : cur.base;
      end
    end

    acc_mac = VALUE_BITS'(acc_cur * VALUE_BITS'(dbase)) + VALUE_BITS'(dval);

    if (dig_en) begin
      ctrl_o.base  = dbase;
      ctrl_o.phase = ttup_pkg::PH_DIGITS;
      if (dval < {1'b0, dbase}) begin
        acc_o = acc_mac;
        cnt_o = cnt_inc;
      end else begin
        emit_o       = 1'b1;
        ctrl_o.phase = ttup_pkg::PH_DONE;
      end
    end
  end

  assign value_o  = cur.negative ? (~acc_cur + VALUE_BITS'(1)) : acc_cur;
  assign offset_o = cnt_cur;

endmodule

// File: rtl/core/text_to_unsigned_parser.sv
// Text to unsigned parser: one character in per transfer, one number out per string.
//
// Input channel: in_valid/in_stall carry in_ch (raw byte) and in_first, which
// marks the first character of a new string. Leading whitespace, one sign and
// a 0x/0X prefix (base 0 or 16) are consumed; base 0 with a leading 0 picks
// octal, otherwise decimal. The first character that is not a digit of the
// base (NUL included) ends the string and produces one result transfer:
// out_value (modulo 2^VALUE_BITS, negated for '-') and out_end_offset
// (characters consumed, saturating). Later characters are dropped until the
// next in_first.
// Throughput: one character per cycle unless a held result stalls the input;
// the whole step (one multiply-add on the accumulator) runs between the input
// register and the state/result registers. The terminating character passes
// the input register, then the result register. While out_stall holds, the
// result stays put and the input register fills, after which in_stall rises.
// cfg_we/cfg_data write the base (reset 10); it is sampled on in_first.
// Synchronous active-low reset clears the valid flags, parse state and accumulator.
`include "assert_macros.svh"

module text_to_unsigned_parser #(
  parameter int unsigned VALUE_BITS  = 32,
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ttup_pkg::BASE_BITS-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_ch,
  input  logic                            in_first,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [VALUE_BITS-1:0]           out_value,
  output logic [OFFSET_BITS-1:0]          out_end_offset
);

  logic [ttup_pkg::BASE_BITS-1:0] number_base_r;

  logic                           in_valid_r;
  logic [7:0]                     in_ch_r;
  logic                           in_first_r;

  ttup_pkg::ttup_ctrl_t           ctrl_r;
  ttup_pkg::ttup_ctrl_t           ctrl_nxt;
  logic [VALUE_BITS-1:0]          acc_r;
  logic [VALUE_BITS-1:0]          acc_nxt;
  logic [OFFSET_BITS-1:0]         cnt_r;
  logic [OFFSET_BITS-1:0]         cnt_nxt;

  logic                           emit;
  logic [VALUE_BITS-1:0]          res_value;
  logic [OFFSET_BITS-1:0]         res_offset;

  logic                           out_valid_r;
  logic [VALUE_BITS-1:0]          out_value_r;
  logic [OFFSET_BITS-1:0]         out_offset_r;

  logic                           out_free;
  logic                           step_fire;

  assign out_free  = !out_valid_r || !out_stall;
  assign step_fire = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r <= ttup_pkg::BASE_RESET;
    end else if (cfg_we) begin
      number_base_r <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_ch_r    <= in_ch;
      in_first_r <= in_first;
    end
  end

  ttup_step #(
    .VALUE_BITS  (VALUE_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_step (
    .ch_i          (in_ch_r),
    .first_i       (in_first_r),
    .number_base_i (number_base_r),
    .ctrl_i        (ctrl_r),
    .acc_i         (acc_r),
    .cnt_i         (cnt_r),
    .ctrl_o        (ctrl_nxt),
    .acc_o         (acc_nxt),
    .cnt_o         (cnt_nxt),
    .emit_o        (emit),
    .value_o       (res_value),
    .offset_o      (res_offset)
  );

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.phase    <= ttup_pkg::PH_IDLE;
      ctrl_r.negative <= 1'b0;
      ctrl_r.base     <= '0;
      acc_r           <= '0;
      cnt_r           <= '0;
    end else if (step_fire) begin
      ctrl_r <= ctrl_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step_fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && emit) begin
      out_value_r  <= res_value;
      out_offset_r <= res_offset;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_end_offset = out_offset_r;

  `TTUP_ASSERT(a_emit_reaches_output, step_fire && emit |=> out_valid_r, "result lost")
  `TTUP_ASSERT(a_done_is_quiet,
    step_fire && !in_first_r && ctrl_r.phase == ttup_pkg::PH_DONE |-> !emit,
    "result after end of string")
  `TTUP_ASSERT(a_idle_holds,
    step_fire && !in_first_r && ctrl_r.phase == ttup_pkg::PH_IDLE
      |=> ctrl_r.phase == ttup_pkg::PH_IDLE,
    "parse started without first")
  `TTUP_ASSERT(a_stall_needs_item, in_stall |-> in_valid_r && out_valid_r,
    "input stalled with free stage")
  `TTUP_ASSERT(a_no_overwrite, out_valid_r && out_stall |-> !step_fire,
    "held result overwritten")

endmodule
